@@ hdl/ketsrt_pkg.sv @@
package ketsrt_pkg;

    localparam int CNT_W = 9;
    localparam int TOTAL_W = 24;

    localparam logic [1:0] REQ_FILL = 2'd0;
    localparam logic [1:0] REQ_GET  = 2'd1;
    localparam logic [1:0] REQ_SORT = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_PAST_CNT  = 2'd1;
    localparam logic [1:0] STAT_PAST_CAP  = 2'd2;

    localparam logic [CNT_W-1:0]   CAP_RESET = 9'd256;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  entry_pos;
        logic [15:0] sort_key;
        logic [31:0] field_ref;
        logic [15:0] field_len;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        key_out;
        logic [31:0]        ref_out;
        logic [15:0]        len_out;
        logic [CNT_W-1:0]   count_out;
        logic [TOTAL_W-1:0] total_len_out;
    } t_rsp;

endpackage

@@ hdl/ketsrt_if.sv @@
interface ketsrt_req_if;
    logic                valid;
    logic                ready;
    ketsrt_pkg::t_req    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ketsrt_rsp_if;
    logic                valid;
    logic                ready;
    ketsrt_pkg::t_rsp    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/ketsrt_ram.sv @@
module ketsrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hdl/ketsrt_ctrl.sv @@
module ketsrt_ctrl #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 16,
    parameter int LEN_BITS    = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    input  ketsrt_pkg::t_req                      i_req,
    output logic                                  o_req_ready,
    input  logic [ketsrt_pkg::CNT_W-1:0]          i_cap,
    input  logic                                  i_rsp_free,
    output logic                                  o_rsp_valid,
    output ketsrt_pkg::t_rsp                      o_rsp,
    output logic                                  o_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]        o_waddr,
    output logic [KEY_BITS+32+LEN_BITS-1:0]       o_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]        o_raddr,
    input  logic [KEY_BITS+32+LEN_BITS-1:0]       i_rdata
);
    import ketsrt_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int WW    = KEY_BITS + 32 + LEN_BITS;
    localparam int SUM_W = LEN_BITS + CNT_W;
    localparam int EXT_W = (SUM_W > TOTAL_W + 1) ? SUM_W : TOTAL_W + 1;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_EXEC  = 9'b000000100,
        ST_SLOAD = 9'b000001000,
        ST_SCAP  = 9'b000010000,
        ST_SCMP  = 9'b000100000,
        ST_SWB   = 9'b001000000,
        ST_DONE  = 9'b010000000,
        ST_SPARE = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [WW-1:0]    r_hold, n_hold;
    logic [AW-1:0]    r_clr, n_clr;

    logic [KEY_BITS-1:0] rd_key, hold_key, new_key;
    logic [31:0]         rd_ref;
    logic [LEN_BITS-1:0] rd_len, new_len;
    logic [AW-1:0]       pos_addr, in_addr;
    logic                fill_ok, get_ok, swap;
    logic [CNT_W-1:0]    pos_ext, fill_count, j_next;
    logic [SUM_W-1:0]    fill_sum;
    logic [EXT_W-1:0]    sum_ext;

    assign rd_key   = i_rdata[LEN_BITS+32 +: KEY_BITS];
    assign rd_ref   = i_rdata[LEN_BITS +: 32];
    assign rd_len   = i_rdata[LEN_BITS-1:0];
    assign hold_key = r_hold[LEN_BITS+32 +: KEY_BITS];
    assign new_key  = KEY_BITS'(32'(r_req.sort_key));
    assign new_len  = LEN_BITS'(32'(r_req.field_len));

    assign pos_addr = AW'(32'(r_req.entry_pos));
    assign in_addr  = AW'(32'(i_req.entry_pos));
    assign pos_ext  = CNT_W'(r_req.entry_pos);

    assign fill_ok    = (32'(r_req.entry_pos) < 32'(i_cap))
                     && (32'(r_req.entry_pos) < TABLE_DEPTH);
    assign get_ok     = pos_ext < r_count;
    assign fill_count = (pos_ext >= r_count) ? pos_ext + 1'b1 : r_count;
    assign fill_sum   = r_sum - SUM_W'(rd_len) + SUM_W'(new_len);

    assign swap   = hold_key > rd_key;
    assign j_next = r_j + 1'b1;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_sum   = r_sum;
        n_req   = r_req;
        n_i     = r_i;
        n_j     = r_j;
        n_hold  = r_hold;
        n_clr   = r_clr;

        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = pos_addr;
        o_wdata     = '0;
        o_raddr     = pos_addr;

        o_rsp = '0;
        o_rsp.status = STAT_OK;

        unique case (r_state)
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_raddr     = in_addr;
                if (i_req_valid) begin
                    n_req = i_req;
                    if (i_req.req_type == REQ_SORT) begin
                        n_i     = '0;
                        n_state = ST_SLOAD;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (i_rsp_free) begin
                    o_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                    unique case (r_req.req_type)
                        REQ_FILL: begin
                            if (fill_ok) begin
                                o_we    = 1'b1;
                                o_wdata = {new_key, r_req.field_ref, new_len};
                                n_count = fill_count;
                                n_sum   = fill_sum;
                            end else begin
                                o_rsp.status = STAT_PAST_CAP;
                            end
                        end
                        REQ_GET: begin
                            if (get_ok) begin
                                o_rsp.key_out = 16'(32'(rd_key));
                                o_rsp.ref_out = rd_ref;
                                o_rsp.len_out = 16'(32'(rd_len));
                            end else begin
                                o_rsp.status = STAT_PAST_CNT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SLOAD: begin
                o_raddr = AW'(32'(r_i));
                if (r_i + 1'b1 >= r_count) begin
                    n_state = ST_DONE;
                end else begin
                    n_j     = r_i + 1'b1;
                    n_state = ST_SCAP;
                end
            end
            ST_SCAP: begin
                n_hold  = i_rdata;
                o_raddr = AW'(32'(r_j));
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                if (swap) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(32'(r_j));
                    o_wdata = r_hold;
                    n_hold  = i_rdata;
                end
                o_raddr = AW'(32'(j_next));
                if (j_next >= r_count) begin
                    n_state = ST_SWB;
                end else begin
                    n_j = j_next;
                end
            end
            ST_SWB: begin
                o_we    = 1'b1;
                o_waddr = AW'(32'(r_i));
                o_wdata = r_hold;
                n_i     = r_i + 1'b1;
                n_state = ST_SLOAD;
            end
            ST_DONE: begin
                if (i_rsp_free) begin
                    o_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        sum_ext = EXT_W'(n_sum);
        o_rsp.count_out     = n_count;
        o_rsp.total_len_out = (sum_ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                            : sum_ext[TOTAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_count <= '0;
            r_sum   <= '0;
            r_clr   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_clr   <= n_clr;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_hold <= n_hold;
    end

endmodule

@@ hdl/keyed_entry_table_sorter_top.sv @@
// channel   dir  beat payload                                          handshake
// i_req     in   req_type, entry_pos, sort_key, field_ref, field_len   valid / ready
// o_rsp     out  status, key_out, ref_out, len_out, count_out,         valid / ready
//                total_len_out
// i_cfg     in   capacity_limit (9 bits)                               i_cfg_we
//
// fill and get: one table read, then the write or the result
// sort runs through the one key comparator: per position load, capture, compare each later entry, write back
// after reset the table is cleared one row a cycle, all TABLE_DEPTH rows, ready low
// one item at a time; a held result stalls only the finish of the next item
module keyed_entry_table_sorter_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 16,
    parameter int LEN_BITS    = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ketsrt_req_if.sink                  i_req,
    ketsrt_rsp_if.source                o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ketsrt_pkg::CNT_W-1:0] i_cfg_wdata
);
    import ketsrt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int WW = KEY_BITS + 32 + LEN_BITS;

    logic [CNT_W-1:0] r_cap;
    logic             r_out_valid;
    t_rsp             r_out;

    logic          rsp_free, rsp_valid;
    t_rsp          rsp;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [WW-1:0] wdata, rdata;

    assign rsp_free      = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (rsp_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid) begin
            r_out <= rsp;
        end
    end

    ketsrt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .LEN_BITS    (LEN_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (i_req.payload),
        .o_req_ready (i_req.ready),
        .i_cap       (r_cap),
        .i_rsp_free  (rsp_free),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    ketsrt_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
